@@ rtl/core/u8d_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

	localparam logic [20:0] REPLACEMENT = 21'h00FFFD;

	typedef struct packed {
		logic [20:0] pv;
		logic [1:0]  need;
		logic [1:0]  seen;
	} dec_state_t;

	typedef struct packed {
		logic [2:0]  cnt;
		logic [20:0] cp;
		logic        bad;
	} run_t;

endpackage

@@ rtl/core/u8d_if.sv @@
// Handshake interfaces for the byte input and code point output channels.
interface u8d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_text;

	modport source (output valid, output data_byte, output end_of_text, input ready);
	modport sink (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface u8d_cp_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic        malformed;
	logic        last_of_run;

	modport source (output valid, output code_point, output malformed, output last_of_run,
		input ready);
	modport sink (input valid, input code_point, input malformed, input last_of_run,
		output ready);
endinterface

@@ rtl/core/utf8_stream_decoder.sv @@
// UTF-8 stream decoder top level: byte input register, decode step, result run register.
//
// Channel text carries one byte of UTF-8 text per transfer with an end_of_text
// mark on the last byte. Channel code carries code points; each byte causes a
// run of zero to four results and the final result of a run has last_of_run set.
// Malformed or truncated sequences give 0xFFFD with malformed set.
// After its transfer a byte is held in the input register; its decode step then
// loads its results into the result register, which offers them on code.
// The decode step of each byte is one short combinational pass, so one byte per
// cycle is sustained while each byte gives at most one result and code.ready
// stays high. A run of n results holds the result register until all n are
// taken, and the next byte waits in the input register meanwhile.
// text.ready depends on code.ready: when the receiver stalls, the last result
// holds, the input register holds its byte and text.ready drops once it is full.
// Reset clears the open sequence, both registers' valid state and the run count;
// the block takes bytes in the first cycle after reset.
module utf8_stream_decoder
	import u8d_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	u8d_byte_if.sink        text,
	u8d_cp_if.source        code
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;

	dec_state_t state_q;
	dec_state_t st_nxt;
	run_t       run_nxt;

	logic [2:0]  run_cnt_q;
	logic [20:0] run_cp_q;
	logic        run_bad_q;

	logic run_free;
	logic adv_s1;

	u8d_step u_step (
		.st          (state_q),
		.data_byte   (byte_s1),
		.end_of_text (eot_s1),
		.st_nxt      (st_nxt),
		.run         (run_nxt)
	);

	assign run_free   = (run_cnt_q == 3'd0) || ((run_cnt_q == 3'd1) && code.ready);
	assign adv_s1     = valid_s1 && run_free;
	assign text.ready = !valid_s1 || run_free;

	assign code.valid       = (run_cnt_q != 3'd0);
	assign code.last_of_run = (run_cnt_q == 3'd1);
	assign code.code_point  = (run_cnt_q == 3'd1) ? run_cp_q : REPLACEMENT;
	assign code.malformed   = (run_cnt_q == 3'd1) ? run_bad_q : 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.data_byte;
			eot_s1  <= text.end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= '0;
			run_cnt_q <= 3'd0;
		end else if (adv_s1) begin
			state_q   <= st_nxt;
			run_cnt_q <= run_nxt.cnt;
		end else if (code.valid && code.ready) begin
			run_cnt_q <= run_cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			run_cp_q  <= run_nxt.cp;
			run_bad_q <= run_nxt.bad;
		end
	end

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_cnt_q <= 3'd4)
		else $error("result run longer than four");

	a_head_is_replacement: assert property (@(posedge clk) disable iff (!arst_n)
		(code.valid && !code.last_of_run) |-> (code.malformed && code.code_point == REPLACEMENT))
		else $error("non-final result of a run is not a replacement");

	a_seq_state: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.need == 2'd0) ? (state_q.seen == 2'd0) : (state_q.seen < state_q.need))
		else $error("continuation count out of range for open sequence");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(run_cnt_q == 3'd0) |-> text.ready)
		else $error("input stalled with empty result register");

	a_eot_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && eot_s1) |=> (state_q.need == 2'd0))
		else $error("sequence left open after end of text");

endmodule

@@ rtl/core/u8d_step.sv @@
// Decode step: next sequence state and the result run caused by one byte.
module u8d_step
	import u8d_pkg::*;
(
	input  dec_state_t st,
	input  logic [7:0] data_byte,
	input  logic       end_of_text,
	output dec_state_t st_nxt,
	output run_t       run
);

	logic        cont;
	logic        open;
	logic [1:0]  seen_new;
	logic [20:0] pv_shift;
	logic [1:0]  lead_need;
	logic [20:0] lead_pv;
	logic [20:0] lead_cp;
	logic        lead_bad;
	logic [2:0]  flush;

	always_comb begin
		cont     = (data_byte[7:6] == 2'b10);
		open     = (st.need != 2'd0);
		seen_new = st.seen + 2'd1;
		pv_shift = {st.pv[14:0], data_byte[5:0]};
		flush    = open ? ({1'b0, st.seen} + 3'd1) : 3'd0;

		lead_need = 2'd0;
		lead_pv   = '0;
		lead_cp   = REPLACEMENT;
		lead_bad  = 1'b1;
		if (data_byte[7] == 1'b0) begin
			lead_cp  = {13'd0, data_byte};
			lead_bad = 1'b0;
		end else if (data_byte[7:5] == 3'b110) begin
			lead_need = 2'd1;
			lead_pv   = {16'd0, data_byte[4:0]};
		end else if (data_byte[7:4] == 4'b1110) begin
			lead_need = 2'd2;
			lead_pv   = {17'd0, data_byte[3:0]};
		end else if (data_byte[7:3] == 5'b11110) begin
			lead_need = 2'd3;
			lead_pv   = {18'd0, data_byte[2:0]};
		end

		st_nxt  = st;
		run.cnt = 3'd0;
		run.cp  = REPLACEMENT;
		run.bad = 1'b1;
		if (open && cont) begin
			if (seen_new >= st.need) begin
				run.cnt = 3'd1;
				run.cp  = pv_shift;
				run.bad = 1'b0;
				st_nxt  = '0;
			end else if (end_of_text) begin
				run.cnt = {1'b0, seen_new} + 3'd1;
				st_nxt  = '0;
			end else begin
				st_nxt.pv   = pv_shift;
				st_nxt.seen = seen_new;
			end
		end else begin
			st_nxt = '0;
			if (lead_need == 2'd0) begin
				run.cnt = flush + 3'd1;
				run.cp  = lead_cp;
				run.bad = lead_bad;
			end else if (end_of_text) begin
				run.cnt = flush + 3'd1;
			end else begin
				run.cnt     = flush;
				st_nxt.pv   = lead_pv;
				st_nxt.need = lead_need;
				st_nxt.seen = 2'd0;
			end
		end
		if (end_of_text) begin
			st_nxt = '0;
		end
	end

endmodule
